>>> src/ssort_pkg.sv
package ssort_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_KEYS = 2'd1;

  typedef struct packed {
    logic descending;
    logic signed_keys;
  } ssort_cfg_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_TEMP,
    ST_CMP,
    ST_PLACE,
    ST_ERD,
    ST_ELD,
    ST_EWAIT
  } ssort_state_t;

endpackage

>>> src/ssort_ram.sv
module ssort_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/ssort_cmp.sv
module ssort_cmp
  import ssort_pkg::*;
(
  input  logic [KEY_BITS-1:0] a,
  input  logic [KEY_BITS-1:0] b,
  input  ssort_cfg_t          cfg,
  output logic                out_of_order
);

  logic [KEY_BITS-1:0] oa;
  logic [KEY_BITS-1:0] ob;

  // flipping the sign bit maps two's complement order onto unsigned order
  always_comb begin
    oa = a;
    ob = b;
    if (cfg.signed_keys) begin
      oa[KEY_BITS-1] = ~a[KEY_BITS-1];
      ob[KEY_BITS-1] = ~b[KEY_BITS-1];
    end
    out_of_order = cfg.descending ? (oa < ob) : (oa > ob);
  end

endmodule

>>> src/shell_sort_engine_core.sv
// shell sort engine core
// input channel (in_valid/in_ready): one key per beat, in_last marks the
// final key of a set. keys are taken one per cycle while loading; keys past
// the 64-entry store are dropped and flagged on every result of that set.
// after the last beat the set is shell sorted in place (gaps n/2 down to 1)
// and then streamed out on the result channel (out_valid/out_ready), one
// beat per key, out_last_out on the final one, out_overflow on all of them.
// sort order is taken from the config registers as they stand when the
// last key is accepted (cfg_we/cfg_index/cfg_wdata, index 0 descending,
// index 1 signed keys).
// steps: each insertion step of the sort fetches its key (fetch, temp),
// compares it once per neighbor (cmp) and writes it with a place step when
// it sinks to the bottom; each result goes through ram read, output load
// and handoff, all paced by the single read and single write port of the
// key ram, and the next result is read only after the last one is taken.
// in_ready is low from the last key until the final result is taken; a
// stalled receiver simply holds the output register and the engine waits.
// reset empties the store, clears the drop flag and the config registers.
module shell_sort_engine_core
  import ssort_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_key,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_sorted_key,
  output logic                 out_last_out,
  output logic                 out_overflow,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata
);

  ssort_state_t state_r, state_nxt;

  // live config registers and the copy used by the running sort
  ssort_cfg_t cfg_r, cfg_nxt;
  ssort_cfg_t sort_cfg_r, sort_cfg_nxt;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                dropped_r, dropped_nxt;
  logic [IDX_W-1:0]    gap_r, gap_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [IDX_W-1:0]    j_r, j_nxt;
  logic [IDX_W-1:0]    e_r, e_nxt;
  logic [KEY_BITS-1:0] temp_r, temp_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic                out_valid_r, out_valid_nxt;

  // ram ports
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;

  logic                ooo;
  logic                room;
  logic [CNT_W-1:0]    count_new;
  logic [IDX_W-1:0]    gap_load;
  logic [IDX_W-1:0]    j_dn;
  logic [CNT_W-1:0]    i_inc;
  logic [IDX_W-1:0]    gap_half;

  ssort_ram #(
    .DEPTH (MAX_KEYS),
    .WIDTH (KEY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // stored neighbor one gap below vs the key being inserted
  ssort_cmp u_cmp (
    .a            (ram_rdata),
    .b            (temp_r),
    .cfg          (sort_cfg_r),
    .out_of_order (ooo)
  );

  assign room      = (count_r < CNT_W'(MAX_KEYS));
  assign count_new = room ? count_r + CNT_W'(1) : count_r;
  assign gap_load  = count_new[CNT_W-1:1];
  assign j_dn      = j_r - gap_r;
  assign i_inc     = i_r + CNT_W'(1);
  assign gap_half  = gap_r >> 1;

  assign in_ready       = (state_r == ST_LOAD);
  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_last_out   = out_last_r;
  assign out_overflow   = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_r;
    sort_cfg_nxt  = sort_cfg_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    gap_nxt       = gap_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    e_nxt         = e_r;
    temp_nxt      = temp_r;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = j_r;
    ram_wdata     = temp_r;
    ram_raddr     = j_dn;

    if (cfg_we) begin
      case (cfg_index)
        CFG_DESCENDING:  cfg_nxt.descending  = cfg_wdata;
        CFG_SIGNED_KEYS: cfg_nxt.signed_keys = cfg_wdata;
        default: ;
      endcase
    end

    // one insertion step is done: move to the next key or the next gap
    if ((state_r == ST_PLACE) || ((state_r == ST_CMP) && !ooo)) begin
      if (i_inc < count_r) begin
        i_nxt = i_inc;
      end else begin
        gap_nxt = gap_half;
        i_nxt   = {1'b0, gap_half};
      end
    end

    case (state_r)
      ST_LOAD: begin
        ram_waddr = count_r[IDX_W-1:0];
        ram_wdata = in_key[KEY_BITS-1:0];
        if (in_valid) begin
          ram_we      = room;
          count_nxt   = count_new;
          dropped_nxt = dropped_r | !room;
          if (in_last) begin
            sort_cfg_nxt = cfg_r;
            gap_nxt      = gap_load;
            i_nxt        = {1'b0, gap_load};
            e_nxt        = '0;
            state_nxt    = (gap_load == '0) ? ST_ERD : ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        ram_raddr = i_r[IDX_W-1:0];
        j_nxt     = i_r[IDX_W-1:0];
        state_nxt = ST_TEMP;
      end
      ST_TEMP: begin
        temp_nxt  = ram_rdata;
        ram_raddr = j_dn;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        ram_we = 1'b1;
        if (ooo) begin
          // neighbor moves up one gap, the inserted key keeps sinking
          ram_wdata = ram_rdata;
          j_nxt     = j_dn;
          ram_raddr = j_dn - gap_r;
          state_nxt = (j_dn >= gap_r) ? ST_CMP : ST_PLACE;
        end else begin
          ram_wdata = temp_r;
          state_nxt = (i_inc < count_r) ? ST_FETCH :
                      (gap_half == '0)  ? ST_ERD : ST_FETCH;
        end
      end
      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_wdata = temp_r;
        state_nxt = (i_inc < count_r) ? ST_FETCH :
                    (gap_half == '0)  ? ST_ERD : ST_FETCH;
      end
      ST_ERD: begin
        ram_raddr = e_r;
        state_nxt = ST_ELD;
      end
      ST_ELD: begin
        out_key_nxt   = ram_rdata;
        out_last_nxt  = (({1'b0, e_r} + CNT_W'(1)) == count_r);
        out_ovf_nxt   = dropped_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = ST_LOAD;
          end else begin
            e_nxt     = e_r + IDX_W'(1);
            state_nxt = ST_ERD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cfg_r       <= '0;
      sort_cfg_r  <= '0;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      gap_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      sort_cfg_r  <= sort_cfg_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      gap_r       <= gap_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      e_r         <= e_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    temp_r     <= temp_nxt;
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

>>> test/tb_top.sv
module tb_top;
  import ssort_pkg::*;

  // sort pass halves the gap each round
  localparam int GAP_DIVISOR   = 2;
  // config indexes past the two real registers, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  // random keys after the directed sets
  localparam int RANDOM_KEYS   = 360;
  // keys per config phase in the random part
  localparam int PHASE_KEYS    = 45;
  // quiet cycles after the last result before touching config or ending
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;

  // one key beat on the way in; hold means wait for all sorted beats first
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                last;
    logic                hold;
  } key_beat_t;

  // one sorted beat as it should come out
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                last;
    logic                dropped;
  } sorted_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [31:0]          in_key = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [31:0]          out_sorted_key;
  logic                 out_last_out;
  logic                 out_overflow;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DESCENDING;
  logic                 cfg_wdata = 1'b0;

  shell_sort_engine_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key         (in_key),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sorted_key (out_sorted_key),
    .out_last_out   (out_last_out),
    .out_overflow   (out_overflow),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // keys waiting to be sent, filled by the stimulus process
  key_beat_t    key_feed_q[$];
  // sorted beats the engine still owes us, oldest first
  sorted_beat_t sorted_out_q[$];

  // shadow of the engine: key store, fill level, drop flag and order setting
  logic [KEY_BITS-1:0] shadow_keys[MAX_KEYS];
  int                  shadow_count = 0;
  bit                  shadow_dropped = 1'b0;
  ssort_cfg_t          shadow_cfg = '0;

  int keys_queued = 0;
  int fail_count = 0;
  int cycle_count = 0;
  // all sorted beats are in and nothing is on the input port, sampled at negedge
  bit drained = 1'b0;

  // idle draw shared by both sides: a random wait drawn from 0..11, with
  // occasional stretches of back-to-back beats
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // true when a has to be emitted after b under the current order setting
  function automatic bit must_follow(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
    logic [KEY_BITS-1:0] oa, ob;
    oa = a;
    ob = b;
    // flipping the sign bit makes unsigned compare follow two's complement order
    if (shadow_cfg.signed_keys) begin
      oa[KEY_BITS-1] = ~a[KEY_BITS-1];
      ob[KEY_BITS-1] = ~b[KEY_BITS-1];
    end
    return shadow_cfg.descending ? (oa < ob) : (oa > ob);
  endfunction

  // in-place shell sort of the first n shadow keys, gaps n/2 down to 1
  task automatic sort_shadow(int n);
    int gap, i, j;
    bit sinking;
    logic [KEY_BITS-1:0] tmp;
    for (gap = n / GAP_DIVISOR; gap > 0; gap = gap / GAP_DIVISOR) begin
      for (i = gap; i < n; i++) begin
        j = i - gap;
        sinking = 1'b1;
        // gapped insertion: swap downward while out of order, equal keys stay
        while (sinking) begin
          if (!must_follow(shadow_keys[j], shadow_keys[j + gap])) begin
            sinking = 1'b0;
          end else begin
            tmp = shadow_keys[j];
            shadow_keys[j] = shadow_keys[j + gap];
            shadow_keys[j + gap] = tmp;
            if (j < gap) sinking = 1'b0;
            else j = j - gap;
          end
        end
      end
    end
  endtask

  // one accepted key: store or drop it, and on the last key of a set
  // sort and queue up every sorted beat the engine has to produce
  task automatic take_key(logic [KEY_BITS-1:0] k, logic is_last);
    int n, i;
    if (shadow_count < MAX_KEYS) begin
      shadow_keys[shadow_count] = k;
      shadow_count++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (is_last) begin
      n = shadow_count;
      sort_shadow(n);
      for (i = 0; i < n; i++) begin
        sorted_out_q.push_back('{key: shadow_keys[i], last: (i == n - 1),
                                 dropped: shadow_dropped});
      end
      shadow_count = 0;
      shadow_dropped = 1'b0;
    end
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver: presents queued keys, idles between beats, holds the beat
  // steady while in_ready is low
  // ---------------------------------------------------------------------------
  int feed_gap = 0;
  int feed_run = 0;

  always @(posedge clk) begin : feed_driver
    key_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        take_key(in_key, in_last);
        feed_gap = draw_wait(feed_run);
      end
      if (in_valid && !in_ready) begin
        // beat still pending, payload stays as it is
      end else if (feed_gap > 0) begin
        feed_gap--;
        in_valid <= 1'b0;
      end else if (key_feed_q.size() != 0 && (!key_feed_q[0].hold || drained)) begin
        nxt = key_feed_q.pop_front();
        in_valid <= 1'b1;
        in_key   <= nxt.key;
        in_last  <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) drained <= (sorted_out_q.size() == 0) && !in_valid;

  // ---------------------------------------------------------------------------
  // result monitor: random backpressure, every taken beat checked against
  // the oldest sorted beat still owed
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int sink_run = 0;

  always @(posedge clk) begin : result_monitor
    sorted_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sorted_out_q.size() == 0) begin
          $display("%0t: unexpected sorted beat, expected none, got key %h last %b ovf %b",
                   $time, out_sorted_key, out_last_out, out_overflow);
          fail_count++;
        end else begin
          want = sorted_out_q.pop_front();
          check_field("sorted_key", want.key, out_sorted_key);
          check_field("last_out", 32'(want.last), 32'(out_last_out));
          check_field("overflow", 32'(want.dropped), 32'(out_overflow));
        end
        stall_left = draw_wait(sink_run);
      end else if (!out_valid && stall_left == 0 && $urandom_range(0, 15) == 0) begin
        // drop ready now and then while idle so the first beat of a set stalls too
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** shell_sort_engine_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_key(logic [KEY_BITS-1:0] k, logic is_last, logic hold);
    key_feed_q.push_back('{key: k, last: is_last, hold: hold});
    keys_queued++;
  endtask

  // mix of full-range keys, tight clusters for duplicates and keys near the
  // sign boundary and the ends of the range
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 7);
      1:       return 32'h7FFF_FFF8 + $urandom_range(0, 15);
      2:       return 32'hFFFF_FFF8 + $urandom_range(0, 7);
      3:       return {1'b1, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // mostly short sets, a few long ones and some that overrun the store
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 12);
    if (r < 92) return $urandom_range(13, 40);
    return $urandom_range(41, MAX_KEYS + 8);
  endfunction

  task automatic queue_set(int size, bit hold);
    int i;
    for (i = 0; i < size; i++) push_key(pick_key(), i == size - 1, hold && i == 0);
  endtask

  // wait until every key is in and every sorted beat is out, then settle
  task automatic wait_idle();
    do @(negedge clk);
    while (key_feed_q.size() != 0 || in_valid || sorted_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_DESCENDING) shadow_cfg.descending = val;
    else if (idx == CFG_SIGNED_KEYS) shadow_cfg.signed_keys = val;
  endtask

  task automatic set_order(bit desc, bit sgn);
    write_reg(CFG_DESCENDING, desc);
    write_reg(CFG_SIGNED_KEYS, sgn);
  endtask

  initial begin : stimulus
    logic [KEY_BITS-1:0] corner_keys[7];
    int i, phase, random_target, phase_end;
    corner_keys = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset order (ascending, unsigned): lone key, then the corner set with
    // duplicates
    wait_idle();
    push_key(32'h8000_0000, 1'b1, 1'b0);
    for (i = 0; i < 7; i++) push_key(corner_keys[i], i == 6, 1'b0);

    // descending signed on the same corners
    wait_idle();
    set_order(1'b1, 1'b1);
    for (i = 0; i < 7; i++) push_key(corner_keys[i], i == 6, 1'b0);

    // ascending signed, writes to spare indexes must change nothing, and the
    // sender holds off until the engine is empty
    wait_idle();
    set_order(1'b0, 1'b1);
    write_reg(CFG_SPARE_2, 1'b1);
    write_reg(CFG_SPARE_3, 1'b1);
    push_key(32'h8000_0000, 1'b0, 1'b1);
    push_key(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_key(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_key(32'h0000_0000, 1'b1, 1'b0);

    // descending unsigned, alternating bit patterns
    wait_idle();
    set_order(1'b1, 1'b0);
    push_key(32'h5555_5555, 1'b0, 1'b0);
    push_key(32'hAAAA_AAAA, 1'b0, 1'b0);
    push_key(32'h0000_0000, 1'b1, 1'b0);

    // random phases: the first four walk all order settings, early phases
    // also carry a full store, a set whose last key is dropped and a long overrun
    random_target = keys_queued + RANDOM_KEYS;
    phase = 0;
    while (keys_queued < random_target) begin
      wait_idle();
      if (phase < 4) set_order(phase[0], phase[1]);
      else set_order(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                  1'($urandom_range(0, 1)));
      phase_end = keys_queued + PHASE_KEYS;
      if (phase == 1) queue_set(MAX_KEYS, 1'b0);
      if (phase == 2) queue_set(MAX_KEYS + 1, 1'b1);
      if (phase == 3) queue_set(MAX_KEYS + 8, 1'b0);
      while (keys_queued < phase_end) queue_set(pick_size(), $urandom_range(0, 7) == 0);
      phase++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("** shell_sort_engine_core: PASSED **");
    end else begin
      $display("** shell_sort_engine_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> shell_sort_engine_core.f
src/ssort_pkg.sv
src/ssort_ram.sv
src/ssort_cmp.sv
src/shell_sort_engine_core.sv
test/tb_top.sv
